@@ rtl/ppt_pkg.sv @@
// shared types and constants for the point in polygon test block
// no dependencies

package ppt_pkg;

   localparam int unsigned DEF_MAX_VERTICES = 64;
   localparam int unsigned DEF_COORD_WIDTH  = 16;

   localparam int unsigned INDEX_WIDTH = 6;
   localparam int unsigned CFG_WIDTH   = 7;
   localparam int unsigned COUNT_MIN   = 3;
   localparam int unsigned COUNT_RESET = 3;

   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned RSP_DEPTH = 2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [INDEX_WIDTH-1:0] vertex_index;
   } cmd_ctrl_type;

endpackage

@@ rtl/ppt_ram.sv @@
// generic single write port ram with registered read
// no dependencies

module ppt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ rtl/ppt_fifo.sv @@
// small register based word queue
// no dependencies

module ppt_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/ppt_front.sv @@
// front end: takes request words, drops out of range vertex writes, queues commands
// depends on ppt_pkg and ppt_fifo

module ppt_front #(
   parameter int unsigned MAX_VERTICES = ppt_pkg::DEF_MAX_VERTICES,
   parameter int unsigned COORD_WIDTH  = ppt_pkg::DEF_COORD_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_kind,
   input  logic [ppt_pkg::INDEX_WIDTH-1:0]    req_vertex_index,
   input  logic signed [COORD_WIDTH-1:0]      req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]      req_coord_y,
   input  logic                               cmd_pop,
   output logic                               cmd_empty,
   output ppt_pkg::cmd_ctrl_type              cmd_ctrl,
   output logic signed [COORD_WIDTH-1:0]      cmd_x,
   output logic signed [COORD_WIDTH-1:0]      cmd_y
);

   localparam int unsigned CTRL_W = $bits(ppt_pkg::cmd_ctrl_type);
   localparam int unsigned FW     = CTRL_W + 2 * COORD_WIDTH;

   ppt_pkg::cmd_ctrl_type ctrl;
   logic                  in_range;
   logic                  keep;
   logic [FW-1:0]         fifo_wdata;
   logic [FW-1:0]         fifo_rdata;

   assign ctrl.kind         = req_kind;
   assign ctrl.vertex_index = req_vertex_index;

   // vertex writes beyond the store are dropped here
   assign in_range   = (32'(req_vertex_index) < MAX_VERTICES);
   assign keep       = push && !full && ((req_kind == ppt_pkg::KIND_QUERY) || in_range);
   assign fifo_wdata = {ctrl, req_coord_x, req_coord_y};

   ppt_fifo #(
      .WIDTH (FW),
      .DEPTH (ppt_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (keep),
      .wdata (fifo_wdata),
      .pop   (cmd_pop),
      .rdata (fifo_rdata),
      .full  (full),
      .empty (cmd_empty)
   );

   assign cmd_ctrl = ppt_pkg::cmd_ctrl_type'(fifo_rdata[FW-1:2*COORD_WIDTH]);
   assign cmd_x    = fifo_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign cmd_y    = fifo_rdata[COORD_WIDTH-1:0];

endmodule

@@ rtl/ppt_back.sv @@
// back end: vertex store, edge walk sequencer and crossing test pipeline
// depends on ppt_pkg and ppt_ram

module ppt_back #(
   parameter int unsigned MAX_VERTICES = ppt_pkg::DEF_MAX_VERTICES,
   parameter int unsigned COORD_WIDTH  = ppt_pkg::DEF_COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ppt_pkg::CFG_WIDTH-1:0]   csr_wdata,
   input  logic                            cmd_empty,
   output logic                            cmd_pop,
   input  ppt_pkg::cmd_ctrl_type           cmd_ctrl,
   input  logic signed [COORD_WIDTH-1:0]   cmd_x,
   input  logic signed [COORD_WIDTH-1:0]   cmd_y,
   input  logic                            rsp_full,
   output logic                            rsp_push,
   output logic                            rsp_inside
);

   localparam int unsigned AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int unsigned VW    = 2 * COORD_WIDTH;
   localparam int unsigned DW    = COORD_WIDTH + 1;
   localparam int unsigned PW    = 2 * DW;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // vertex count register
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      priority if (csr_wdata < ppt_pkg::CFG_WIDTH'(ppt_pkg::COUNT_MIN)) begin
         cnt_in = CNT_W'(ppt_pkg::COUNT_MIN);
      end else if (32'(csr_wdata) > MAX_VERTICES) begin
         cnt_in = CNT_W'(MAX_VERTICES);
      end else begin
         cnt_in = CNT_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(ppt_pkg::COUNT_RESET);
      end else if (csr_we) begin
         cnt_ff <= cnt_in;
      end
   end

   // sequencer
   logic [1:0]                    state_ff, state_in;
   logic [AW-1:0]                 addr_ff, addr_in;
   logic [AW-1:0]                 last_addr_ff, last_addr_in;
   logic                          first_ff, first_in;
   logic signed [COORD_WIDTH-1:0] pt_x_ff, pt_x_in;
   logic signed [COORD_WIDTH-1:0] pt_y_ff, pt_y_in;
   logic                          ram_we;
   logic                          start;
   logic                          rd_en;
   logic                          rd_last;
   logic                          s3_valid_ff;
   logic                          s3_last_ff;

   assign rd_en   = (state_ff == ST_WALK);
   assign rd_last = !first_ff && (addr_ff == last_addr_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      last_addr_in = last_addr_ff;
      first_in     = first_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      start        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_ctrl.kind == ppt_pkg::KIND_WRITE) begin
                  cmd_pop = 1'b1;
                  ram_we  = 1'b1;
               end else if (!rsp_full) begin
                  cmd_pop      = 1'b1;
                  start        = 1'b1;
                  state_in     = ST_WALK;
                  // walk starts at the last vertex, then 0 upward
                  addr_in      = AW'(cnt_ff - CNT_W'(1));
                  last_addr_in = AW'(cnt_ff - CNT_W'(1));
                  first_in     = 1'b1;
                  pt_x_in      = cmd_x;
                  pt_y_in      = cmd_y;
               end
            end
         end
         ST_WALK: begin
            if (first_ff) begin
               first_in = 1'b0;
               addr_in  = '0;
            end else if (addr_ff == last_addr_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (s3_valid_ff && s3_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      last_addr_ff <= last_addr_in;
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
   end

   // vertex store
   logic [AW-1:0] ram_waddr;
   logic [VW-1:0] ram_wdata;
   logic [VW-1:0] rd_data;

   assign ram_waddr = AW'(cmd_ctrl.vertex_index);
   assign ram_wdata = {cmd_x, cmd_y};

   ppt_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (rd_data)
   );

   // stage 1: vertex read data, edge differences
   logic                          s1_valid_ff;
   logic                          s1_first_ff;
   logic                          s1_last_ff;
   logic signed [COORD_WIDTH-1:0] vi_x, vi_y;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic signed [DW-1:0]          s2_a_in, s2_dy_in, s2_c_in, s2_e_in;
   logic                          s2_cross_in, s2_dypos_in;

   assign vi_x = rd_data[VW-1:COORD_WIDTH];
   assign vi_y = rd_data[COORD_WIDTH-1:0];

   assign s2_a_in     = DW'(pt_x_ff) - DW'(vi_x);
   assign s2_c_in     = DW'(prev_x_ff) - DW'(vi_x);
   assign s2_e_in     = DW'(pt_y_ff) - DW'(vi_y);
   assign s2_dy_in    = DW'(prev_y_ff) - DW'(vi_y);
   assign s2_dypos_in = !s2_dy_in[DW-1] && (s2_dy_in != '0);
   assign s2_cross_in = !s1_first_ff && ((vi_y > pt_y_ff) != (prev_y_ff > pt_y_ff));

   // stage 2: products
   logic                 s2_valid_ff;
   logic                 s2_last_ff;
   logic                 s2_cross_ff;
   logic                 s2_dypos_ff;
   logic signed [DW-1:0] s2_a_ff, s2_dy_ff, s2_c_ff, s2_e_ff;
   logic signed [PW-1:0] p1_in, p2_in;

   assign p1_in = PW'(s2_a_ff) * PW'(s2_dy_ff);
   assign p2_in = PW'(s2_c_ff) * PW'(s2_e_ff);

   // stage 3: compare and toggle
   logic                 s3_cross_ff;
   logic                 s3_dypos_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic                 left;
   logic                 inside_ff, inside_next;

   assign left        = s3_dypos_ff ? (p1_ff < p2_ff) : (p2_ff < p1_ff);
   assign inside_next = inside_ff ^ (s3_cross_ff && left);
   assign rsp_push    = s3_valid_ff && s3_last_ff;
   assign rsp_inside  = inside_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         inside_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (start) begin
            inside_ff <= 1'b0;
         end else if (s3_valid_ff) begin
            inside_ff <= inside_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= first_ff;
      s1_last_ff  <= rd_last;
      if (s1_valid_ff) begin
         prev_x_ff <= vi_x;
         prev_y_ff <= vi_y;
      end
      s2_last_ff  <= s1_last_ff;
      s2_cross_ff <= s2_cross_in;
      s2_dypos_ff <= s2_dypos_in;
      s2_a_ff     <= s2_a_in;
      s2_dy_ff    <= s2_dy_in;
      s2_c_ff     <= s2_c_in;
      s2_e_ff     <= s2_e_in;
      s3_last_ff  <= s2_last_ff;
      s3_cross_ff <= s2_cross_ff;
      s3_dypos_ff <= s2_dypos_ff;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
   end

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result word pushed into a full queue");

   a_pipe_in_query: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff || s3_valid_ff) |-> (state_ff != ST_IDLE))
      else $error("edge pipeline busy while sequencer idle");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (state_ff == ST_IDLE) && !s3_valid_ff)
      else $error("query did not end with its result word");

endmodule

@@ rtl/point_in_polygon_test.sv @@
// top level of the point in polygon test block
// depends on ppt_pkg, ppt_fifo, ppt_front and ppt_back
//
// usage:
//   request side is a queue: drive push with req_kind, req_vertex_index,
//   req_coord_x and req_coord_y; a word is taken at a clock edge with push
//   high and full low. kind write stores one vertex and gives no result,
//   kind query gives one result word with rsp_inside_res.
//   result side is a queue: while empty is low the oldest result is on
//   rsp_inside_res; it is taken at an edge with pop high and empty low.
//   csr_we with csr_wdata sets the vertex count, saturated to 3..MAX_VERTICES;
//   write it only while no query is pending.
//   a vertex write is handled by the back end while it is idle. a query
//   occupies it for one vertex memory read per edge plus the wrap-around
//   read and a three stage crossing pipeline; the result word is pushed
//   when the last edge leaves stage 3 of that pipeline.
//   a 4 word command queue sits between the front and the back end, and a
//   2 word result queue on the output, so requests keep flowing while a
//   result waits; a query does not start while the result queue is full.
//   reset clears both queues and sets the vertex count to 3; vertex memory
//   contents are undefined until written.

module point_in_polygon_test #(
   parameter int unsigned MAX_VERTICES = ppt_pkg::DEF_MAX_VERTICES,
   parameter int unsigned COORD_WIDTH  = ppt_pkg::DEF_COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_kind,
   input  logic [ppt_pkg::INDEX_WIDTH-1:0] req_vertex_index,
   input  logic signed [COORD_WIDTH-1:0]   req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]   req_coord_y,
   output logic                            empty,
   input  logic                            pop,
   output logic                            rsp_inside_res,
   input  logic                            csr_we,
   input  logic [ppt_pkg::CFG_WIDTH-1:0]   csr_wdata
);

   logic                          cmd_pop;
   logic                          cmd_empty;
   ppt_pkg::cmd_ctrl_type         cmd_ctrl;
   logic signed [COORD_WIDTH-1:0] cmd_x;
   logic signed [COORD_WIDTH-1:0] cmd_y;
   logic                          rsp_full;
   logic                          rsp_push;
   logic                          rsp_inside;
   logic [0:0]                    rsp_wdata;
   logic [0:0]                    rsp_rdata;

   ppt_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .cmd_pop          (cmd_pop),
      .cmd_empty        (cmd_empty),
      .cmd_ctrl         (cmd_ctrl),
      .cmd_x            (cmd_x),
      .cmd_y            (cmd_y)
   );

   ppt_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .cmd_ctrl   (cmd_ctrl),
      .cmd_x      (cmd_x),
      .cmd_y      (cmd_y),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_inside (rsp_inside)
   );

   assign rsp_wdata = rsp_inside;

   ppt_fifo #(
      .WIDTH (1),
      .DEPTH (ppt_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .pop   (pop),
      .rdata (rsp_rdata),
      .full  (rsp_full),
      .empty (empty)
   );

   assign rsp_inside_res = rsp_rdata[0];

endmodule
